[hw/rtl/ilir_pkg.sv]
// shared constants, command codes, controller states and transaction types for the indexed list
package ilir_pkg;

   localparam int DEPTH      = 64;
   localparam int WORD_BITS  = 32;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SET    = 2'd2,
      CMD_GET    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      command_type                  command;
      logic [COUNT_BITS-1:0]        position;
      logic signed [WORD_BITS-1:0]  write_word;
   } req_type;

   typedef struct packed {
      logic                         ok;
      logic signed [WORD_BITS-1:0]  read_word;
      logic [COUNT_BITS-1:0]        entry_count;
   } rsp_type;

endpackage

[hw/rtl/ilir_ram.sv]
// simple dual-port synchronous ram, one write port and one registered read port
module ilir_ram #(
   parameter int RAM_DEPTH = 64,
   parameter int DATA_BITS = 32,
   localparam int RAM_ADDR_BITS = $clog2(RAM_DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [RAM_ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [RAM_ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem [RAM_DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/indexed_list_insert_remove.sv]
// top level of the indexed list: command sequencer around a single entry ram
//
// channel  direction  payload    handshake
// req_     in         req_type   req_valid / req_stall   (command, position, write_word)
// rsp_     out        rsp_type   rsp_valid / rsp_stall   (ok, read_word, entry_count)
//
// sequence: set, get, any failing command, a tail insert and a last-entry remove skip the shift;
//   other inserts shift m entries and then write the new word, other removes shift m entries,
//   m = entries moved; the ram's single write port moves one entry per cycle
// reset: synchronous, clears the entry count, the controller and the result valid flag;
//   entry contents stay undefined until written
// stalls: a finished result sits in the output register while the next transaction
//   is taken; the controller waits in its respond state only if that register is still full
module indexed_list_insert_remove
   import ilir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // controller and operation registers
   state_type               state_ff, state_in;
   command_type             op_cmd_ff, op_cmd_in;
   logic [WORD_BITS-1:0]    op_word_ff, op_word_in;
   logic [ADDR_BITS-1:0]    op_pos_ff, op_pos_in;
   logic                    ok_ff, ok_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   // shift sequencer
   logic [ADDR_BITS-1:0]    rd_addr_ff, rd_addr_in;
   logic [COUNT_BITS-1:0]   left_ff, left_in;
   logic                    wr_pend_ff, wr_pend_in;
   logic [ADDR_BITS-1:0]    wr_addr_ff, wr_addr_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // ram ports
   logic                    mem_wr_en;
   logic [ADDR_BITS-1:0]    mem_wr_addr;
   logic [WORD_BITS-1:0]    mem_wr_data;
   logic                    mem_rd_en;
   logic [ADDR_BITS-1:0]    mem_rd_addr;
   logic [WORD_BITS-1:0]    mem_q;

   // decode of the incoming transaction against the current count
   logic                    ins_ok;
   logic                    pos_ok;
   logic                    at_end;
   logic                    at_last;
   logic                    slot_free;
   logic [COUNT_BITS-1:0]   count_dec;
   logic [COUNT_BITS-1:0]   pos_inc;

   assign count_dec = count_ff - COUNT_BITS'(1);
   assign pos_inc   = req_data.position + COUNT_BITS'(1);
   assign ins_ok    = (req_data.position <= count_ff) && (count_ff < COUNT_BITS'(DEPTH));
   assign pos_ok    = req_data.position < count_ff;
   // insert at the tail moves nothing, nor does removing the last entry
   assign at_end    = req_data.position == count_ff;
   assign at_last   = req_data.position == count_dec;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   ilir_ram #(
      .RAM_DEPTH (DEPTH),
      .DATA_BITS (WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RESPOND;
               if (req_data.command == CMD_INSERT && ins_ok && !at_end) begin
                  state_in = ST_SHIFT;
               end
               if (req_data.command == CMD_REMOVE && pos_ok && !at_last) begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (left_ff == '0) begin
               state_in = (op_cmd_ff == CMD_INSERT) ? ST_FINISH : ST_RESPOND;
            end
         end
         ST_FINISH: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath, ram control and result
   always_comb begin
      op_cmd_in    = op_cmd_ff;
      op_word_in   = op_word_ff;
      op_pos_in    = op_pos_ff;
      ok_in        = ok_ff;
      count_in     = count_ff;
      rd_addr_in   = rd_addr_ff;
      left_in      = left_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = op_pos_ff;
      mem_wr_data  = op_word_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rd_addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_cmd_in  = req_data.command;
               op_word_in = req_data.write_word;
               op_pos_in  = req_data.position[ADDR_BITS-1:0];
               case (req_data.command)
                  CMD_INSERT: begin
                     ok_in = ins_ok;
                     if (ins_ok) begin
                        count_in = count_ff + COUNT_BITS'(1);
                        if (at_end) begin
                           mem_wr_en   = 1'b1;
                           mem_wr_addr = req_data.position[ADDR_BITS-1:0];
                           mem_wr_data = req_data.write_word;
                        end
                        // walk down from the tail, each entry one place up
                        rd_addr_in = count_dec[ADDR_BITS-1:0];
                        left_in    = count_ff - req_data.position;
                     end
                  end
                  CMD_REMOVE: begin
                     ok_in = pos_ok;
                     if (pos_ok) begin
                        count_in = count_dec;
                        // walk up from the entry after the hole, each one place down
                        rd_addr_in = pos_inc[ADDR_BITS-1:0];
                        left_in    = count_dec - req_data.position;
                     end
                  end
                  CMD_SET: begin
                     ok_in = pos_ok;
                     if (pos_ok) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = req_data.position[ADDR_BITS-1:0];
                        mem_wr_data = req_data.write_word;
                     end
                  end
                  CMD_GET: begin
                     ok_in = pos_ok;
                     if (pos_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = req_data.position[ADDR_BITS-1:0];
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // write back the entry read in the previous cycle
            if (wr_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_addr_ff;
               mem_wr_data = mem_q;
            end
            if (left_ff != '0) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_addr_ff;
               wr_pend_in  = 1'b1;
               left_in     = left_ff - COUNT_BITS'(1);
               if (op_cmd_ff == CMD_INSERT) begin
                  wr_addr_in = rd_addr_ff + ADDR_BITS'(1);
                  rd_addr_in = rd_addr_ff - ADDR_BITS'(1);
               end else begin
                  wr_addr_in = rd_addr_ff - ADDR_BITS'(1);
                  rd_addr_in = rd_addr_ff + ADDR_BITS'(1);
               end
            end
         end
         ST_FINISH: begin
            // new word into the gap opened by the shift
            mem_wr_en   = 1'b1;
            mem_wr_addr = op_pos_ff;
            mem_wr_data = op_word_ff;
         end
         ST_RESPOND: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ok          = ok_ff;
               rsp_data_in.read_word   = (op_cmd_ff == CMD_GET && ok_ff) ? mem_q : '0;
               rsp_data_in.entry_count = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_cmd_ff   <= op_cmd_in;
      op_word_ff  <= op_word_in;
      op_pos_ff   <= op_pos_in;
      ok_ff       <= ok_in;
      rd_addr_ff  <= rd_addr_in;
      left_ff     <= left_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("entry count beyond depth");

   // a move never reads the entry it writes in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
      else $error("ram read and write at the same address");

   // a pending write-back only lives inside the shift
   a_pend_in_shift: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> state_ff == ST_SHIFT)
      else $error("write-back pending outside shift");

   // a failed command returns a zero word
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.ok |-> rsp_data_ff.read_word == '0)
      else $error("failed command returned data");

   // the count moves only while a transaction is taken
   a_count_on_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> count_ff == $past(count_ff))
      else $error("entry count changed outside accept");

endmodule
